// ----- sv/dpsm_pkg.sv -----
package dpsm_pkg;

  // Drive state codes
  localparam logic [2:0] ST_NOT_READY = 3'd0;
  localparam logic [2:0] ST_DISABLED  = 3'd1;
  localparam logic [2:0] ST_READY     = 3'd2;
  localparam logic [2:0] ST_ON        = 3'd3;
  localparam logic [2:0] ST_ENABLED   = 3'd4;
  localparam logic [2:0] ST_QSTOP     = 3'd5;
  localparam logic [2:0] ST_FREACT    = 3'd6;
  localparam logic [2:0] ST_FAULT     = 3'd7;

  // Transition codes
  localparam logic [3:0] TR_NONE      = 4'd0;
  localparam logic [3:0] TR_1         = 4'd1;
  localparam logic [3:0] TR_2         = 4'd2;
  localparam logic [3:0] TR_3         = 4'd3;
  localparam logic [3:0] TR_4         = 4'd4;
  localparam logic [3:0] TR_5         = 4'd5;
  localparam logic [3:0] TR_6         = 4'd6;
  localparam logic [3:0] TR_7         = 4'd7;
  localparam logic [3:0] TR_8         = 4'd8;
  localparam logic [3:0] TR_9         = 4'd9;
  localparam logic [3:0] TR_10        = 4'd10;
  localparam logic [3:0] TR_11        = 4'd11;
  localparam logic [3:0] TR_12        = 4'd12;
  localparam logic [3:0] TR_FR_FAULT  = 4'd13;
  localparam logic [3:0] TR_FAULT_DIS = 4'd14;
  localparam logic [3:0] TR_RDY_EN    = 4'd15;

  // Application layer status: operational
  localparam logic [15:0] LINK_OP = 16'd8;

  // Drive flag bits: {brake, hv, axis, cfg}
  localparam logic [3:0] FL_NONE  = 4'b0000;
  localparam logic [3:0] FL_CFG   = 4'b0001;
  localparam logic [3:0] FL_AXIS  = 4'b0010;
  localparam logic [3:0] FL_HV    = 4'b0100;
  localparam logic [3:0] FL_BRAKE = 4'b1000;

  // Result of one state machine step
  typedef struct packed {
    logic [2:0] next_state;
    logic [3:0] trans;
    logic [3:0] flags;
  } dpsm_step_t;

  // Statusword code of a state
  function automatic logic [15:0] status_of_state(input logic [2:0] st);
    logic [15:0] sw;
    case (st)
      ST_NOT_READY: sw = 16'h0000;
      ST_DISABLED:  sw = 16'h0040;
      ST_READY:     sw = 16'h0021;
      ST_ON:        sw = 16'h0023;
      ST_ENABLED:   sw = 16'h0027;
      ST_QSTOP:     sw = 16'h0007;
      ST_FREACT:    sw = 16'h000F;
      default:      sw = 16'h0008;
    endcase
    return sw;
  endfunction

endpackage

// ----- sv/dpsm_step.sv -----
module dpsm_step
  import dpsm_pkg::*;
(
  input  logic [15:0] controlword,
  input  logic [15:0] link_status,
  input  logic [2:0]  cur_state,
  input  logic [3:0]  cur_flags,
  output dpsm_step_t  step
);

  logic link_op;
  logic shutdown, sw_on, sw_on_en, dis_volt, qstop, dis_op, en_op, f_reset;
  logic [2:0] ns;
  logic [3:0] tr;

  // Command decode by masks
  assign link_op  = (link_status == LINK_OP);
  assign shutdown = ((controlword & 16'h0087) == 16'h0006);
  assign sw_on    = ((controlword & 16'h0087) == 16'h0007);
  assign sw_on_en = ((controlword & 16'h008F) == 16'h000F);
  assign dis_volt = ((controlword & 16'h0082) == 16'h0000);
  assign qstop    = ((controlword & 16'h0086) == 16'h0002);
  assign dis_op   = ((controlword & 16'h008F) == 16'h0007);
  assign en_op    = ((controlword & 16'h008F) == 16'h000F);
  assign f_reset  = controlword[7];

  // Next state; first matching command wins
  always_comb begin
    ns = cur_state;
    tr = TR_NONE;
    unique case (cur_state)
      ST_NOT_READY: begin
        if (link_op) begin ns = ST_DISABLED; tr = TR_1; end
      end
      ST_DISABLED: begin
        if (shutdown || link_op) begin ns = ST_READY; tr = TR_2; end
      end
      ST_READY: begin
        if (dis_volt) begin
          ns = ST_DISABLED; tr = TR_7;
        end else if (sw_on) begin
          if (sw_on_en) begin ns = ST_ENABLED; tr = TR_RDY_EN; end
          else begin ns = ST_ON; tr = TR_3; end
        end
      end
      ST_ON: begin
        if (shutdown) begin ns = ST_READY; tr = TR_6; end
        else if (en_op) begin ns = ST_ENABLED; tr = TR_4; end
        else if (dis_volt) begin ns = ST_DISABLED; tr = TR_10; end
      end
      ST_ENABLED: begin
        if (dis_op) begin ns = ST_ON; tr = TR_5; end
        else if (shutdown) begin ns = ST_READY; tr = TR_8; end
        else if (dis_volt || !link_op) begin ns = ST_DISABLED; tr = TR_9; end
        else if (qstop) begin ns = ST_QSTOP; tr = TR_11; end
      end
      ST_QSTOP: begin
        if (dis_volt) begin ns = ST_DISABLED; tr = TR_12; end
      end
      ST_FREACT: begin
        ns = ST_FAULT; tr = TR_FR_FAULT;
      end
      default: begin
        if (f_reset) begin ns = ST_DISABLED; tr = TR_FAULT_DIS; end
      end
    endcase
  end

  // Flags follow the new state; not ready and fault reaction keep them
  always_comb begin
    step.next_state = ns;
    step.trans      = tr;
    case (ns)
      ST_DISABLED, ST_READY: step.flags = FL_CFG | FL_BRAKE;
      ST_ON:                 step.flags = FL_CFG | FL_HV | FL_BRAKE;
      ST_ENABLED, ST_QSTOP:  step.flags = FL_AXIS | FL_HV;
      ST_FAULT:              step.flags = FL_CFG;
      default:               step.flags = cur_flags;
    endcase
  end

endmodule

// ----- sv/drive_power_state_machine.sv -----
// Drive power state machine (CiA402 style) with one statusword per item.
// Input channel in_*: one item carries a controlword and the fieldbus
// application layer status. Result channel out_*: one item per input with
// the statusword, the transition that fired, the state code and four
// drive flags.
// An accepted item is held in the input register, and the result register
// loads from it once the output register is free or draining; out_tvalid
// rises with that load. Throughput: one item per cycle while out_tready stays
// high, set by the single state register update per item.
// Reset (rst_n low, synchronous): drive state returns to not ready to
// switch on, flags clear, both pipeline registers empty.
// When the receiver stalls the result is held stable, the input register
// still takes one more item, and then in_tready drops until out_tready
// returns.
module drive_power_state_machine
  import dpsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] controlword, [31:16] link_status
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] status_word, [19:16] transition_code,
                                  // [22:20] state_code, [23] setup_ok,
                                  // [24] axis_enabled, [25] power_applied,
                                  // [26] brake_on, [31:27] zero
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [15:0] cw_r, link_r;
  logic [2:0]  state_r;
  logic [3:0]  flags_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] sw_r;
  logic [3:0]  tr_r;
  logic        s2_load;
  dpsm_step_t  step;

  // Handshake: stage 2 loads when output register is free or draining
  assign s2_load      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || s2_load;
  assign s1_valid_nxt = (in_tvalid && in_tready) || (s1_valid_r && !s2_load);
  assign out_valid_nxt = s2_load || (out_valid_r && !out_tready);

  dpsm_step u_step (
    .controlword (cw_r),
    .link_status (link_r),
    .cur_state   (state_r),
    .cur_flags   (flags_r),
    .step        (step)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_NOT_READY;
      flags_r     <= FL_NONE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s2_load) begin
        state_r <= step.next_state;
        flags_r <= step.flags;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cw_r   <= in_tdata[15:0];
      link_r <= in_tdata[31:16];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s2_load) begin
      sw_r <= status_of_state(step.next_state);
      tr_r <= step.trans;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, flags_r[3], flags_r[2], flags_r[1], flags_r[0],
                       state_r, tr_r, sw_r};

endmodule
